>>> rtl/pcs_pkg.sv
// Package for the pointer count scaler: widths, register codes, reset values and shared types.
// Every other file of the block depends on it through scoped names.
package pcs_pkg;

    // Fixed-point format and saturation limits.
    localparam int FRACTION_BITS = 8;
    localparam int COUNT_LIMIT   = 512;
    localparam int PIXEL_LIMIT   = 512;

    // Fixed field widths.
    localparam int RAW_W   = 16;
    localparam int PIXEL_W = 11;
    localparam int MULT_W  = 12;
    localparam int STEP_W  = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Derived datapath widths.
    localparam int COUNT_W      = $clog2(COUNT_LIMIT + 1) + 1;
    localparam int CURVE_GAIN_W = FRACTION_BITS + 2;
    localparam int GAIN_W       = (MULT_W > CURVE_GAIN_W) ? MULT_W : CURVE_GAIN_W;
    localparam int PROD_W       = COUNT_W + GAIN_W + 1;
    localparam int SUM_W        = PROD_W + 1;
    localparam int REM_W        = FRACTION_BITS + 1;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CURVE_MODE   = 3'd0,
        CFG_MULTIPLIER   = 3'd1,
        CFG_CURVE_STEP   = 3'd2,
        CFG_CARRY_ENABLE = 3'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic              RST_CURVE_MODE   = 1'b0;
    localparam logic [MULT_W-1:0] RST_MULTIPLIER   = 12'd256;
    localparam logic [STEP_W-1:0] RST_CURVE_STEP   = 4'd2;
    localparam logic              RST_CARRY_ENABLE = 1'b1;

    // Configuration register bank.
    typedef struct packed {
        logic              curve_mode;
        logic [MULT_W-1:0] multiplier;
        logic [STEP_W-1:0] curve_step;
        logic              carry_enable;
    } cfg_t;

    // Control from the pipeline to the accumulator.
    typedef struct packed {
        logic advance;
        logic zero_count;
        logic carry;
    } acc_ctrl_t;

endpackage

>>> rtl/pcs_in_if.sv
// Input channel of the pointer count scaler: valid/ready plus the raw count.
// Depends on pcs_pkg.
interface pcs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [pcs_pkg::RAW_W-1:0]  raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink (input valid, input raw_count, output ready);
endinterface

>>> rtl/pcs_out_if.sv
// Output channel of the pointer count scaler: valid/ready plus the pixel move.
// Depends on pcs_pkg.
interface pcs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pcs_pkg::PIXEL_W-1:0] pixel_move;

    modport source (output valid, output pixel_move, input ready);
    modport sink (input valid, input pixel_move, output ready);
endinterface

>>> rtl/pcs_cfg_regs.sv
// Configuration register bank of the pointer count scaler.
// Depends on pcs_pkg.
module pcs_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output pcs_pkg::cfg_t                      cfg
);

    pcs_pkg::cfg_t cfg_reg;
    pcs_pkg::cfg_t cfg_next;

    // Decode a write; an unknown index leaves the bank unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pcs_pkg::CFG_CURVE_MODE:   cfg_next.curve_mode   = cfg_data[0];
                pcs_pkg::CFG_MULTIPLIER:   cfg_next.multiplier   =
                    cfg_data[pcs_pkg::MULT_W-1:0];
                pcs_pkg::CFG_CURVE_STEP:   cfg_next.curve_step   =
                    cfg_data[pcs_pkg::STEP_W-1:0];
                pcs_pkg::CFG_CARRY_ENABLE: cfg_next.carry_enable = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_mode   <= pcs_pkg::RST_CURVE_MODE;
            cfg_reg.multiplier   <= pcs_pkg::RST_MULTIPLIER;
            cfg_reg.curve_step   <= pcs_pkg::RST_CURVE_STEP;
            cfg_reg.carry_enable <= pcs_pkg::RST_CARRY_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/pcs_gain_select.sv
// Count saturation and gain selection (direct multiplier or stepped curve).
// Depends on pcs_pkg.
module pcs_gain_select (
    input  pcs_pkg::cfg_t                       cfg,
    input  logic signed [pcs_pkg::RAW_W-1:0]    raw_count,
    output logic signed [pcs_pkg::COUNT_W-1:0]  count,
    output logic [pcs_pkg::GAIN_W-1:0]          gain
);

    localparam int RW  = pcs_pkg::RAW_W;
    localparam int CW  = pcs_pkg::COUNT_W;
    localparam int CGW = pcs_pkg::CURVE_GAIN_W;
    localparam int GW  = pcs_pkg::GAIN_W;
    localparam int FB  = pcs_pkg::FRACTION_BITS;

    logic [RW-1:0]  mag;
    logic [RW-1:0]  mag_adj;
    logic [CW-2:0]  mag_lim;
    logic [2:0]     step_eff;
    logic [CGW-1:0] curve_gain;

    // Magnitude of the count; the most negative count still fits unsigned.
    assign mag = raw_count[RW-1] ? RW'(-raw_count) : RW'(raw_count);

    // The curve maps a magnitude of two to three; one stays one.
    assign mag_adj = (cfg.curve_mode && mag == RW'(2)) ? RW'(3) : mag;

    // Saturate the magnitude, then put the sign back.
    assign mag_lim = (mag_adj > RW'(pcs_pkg::COUNT_LIMIT)) ?
                     (CW-1)'(pcs_pkg::COUNT_LIMIT) : mag_adj[CW-2:0];
    assign count   = raw_count[RW-1] ? -$signed({1'b0, mag_lim}) : $signed({1'b0, mag_lim});

    // Curve gain: 1 + step/2 (step 0 or >3 acts as 4), + 1/2 for fast motion.
    assign step_eff   = (cfg.curve_step >= 4'd1 && cfg.curve_step <= 4'd3) ?
                        cfg.curve_step[2:0] : 3'd4;
    assign curve_gain = (CGW'(1) << FB) + (CGW'(step_eff) << (FB - 1))
                      + ((mag_adj > RW'(4)) ? (CGW'(1) << (FB - 1)) : CGW'(0));

    assign gain = cfg.curve_mode ? GW'(curve_gain) : GW'(cfg.multiplier);

endmodule

>>> rtl/pcs_accum.sv
// Multiply, sub-pixel remainder accumulation, truncating divide and output clamp.
// Holds the remainder register. Depends on pcs_pkg.
module pcs_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcs_pkg::acc_ctrl_t                  ctrl,
    input  logic signed [pcs_pkg::COUNT_W-1:0]  count,
    input  logic [pcs_pkg::GAIN_W-1:0]          gain,
    output logic signed [pcs_pkg::PIXEL_W-1:0]  pixel_move,
    output logic signed [pcs_pkg::REM_W-1:0]    remainder
);

    localparam int FB  = pcs_pkg::FRACTION_BITS;
    localparam int PW  = pcs_pkg::PROD_W;
    localparam int SW  = pcs_pkg::SUM_W;
    localparam int RMW = pcs_pkg::REM_W;
    localparam logic signed [SW-1:0] PIX_MAX = SW'(pcs_pkg::PIXEL_LIMIT);
    localparam logic signed [SW-1:0] PIX_MIN = -SW'(pcs_pkg::PIXEL_LIMIT);

    logic signed [RMW-1:0]           remainder_reg;
    logic signed [RMW-1:0]           remainder_next;
    logic signed [pcs_pkg::GAIN_W:0] gain_s;
    logic signed [PW-1:0]            product;
    logic signed [RMW-1:0]           rem_used;
    logic signed [SW-1:0]            sum;
    logic signed [SW-1:0]            quotient;
    logic signed [SW-1:0]            pix_clamped;
    logic [FB-1:0]                   frac;
    logic                            round_up;
    logic signed [RMW-1:0]           rest;
    logic signed [RMW-1:0]           rem_bias;
    logic signed [RMW-1:0]           rem_half;

    // Scale the count and add the kept remainder when carry is on.
    assign gain_s   = $signed({1'b0, gain});
    assign product  = PW'(count) * PW'(gain_s);
    assign rem_used = ctrl.carry ? remainder_reg : '0;
    assign sum      = SW'(product) + SW'(rem_used);

    // Truncate toward zero: a negative sum with a fraction rounds the floor up.
    assign frac     = sum[FB-1:0];
    assign round_up = sum[SW-1] && (frac != '0);
    assign quotient = (sum >>> FB) + $signed({{(SW-1){1'b0}}, round_up});
    assign rest     = round_up ? $signed({1'b1, frac}) : $signed({1'b0, frac});

    // Saturate the whole-pixel result.
    always_comb
    begin
        priority if (quotient > PIX_MAX)
            pix_clamped = PIX_MAX;
        else if (quotient < PIX_MIN)
            pix_clamped = PIX_MIN;
        else
            pix_clamped = quotient;
    end

    assign pixel_move = ctrl.zero_count ? '0 : pcs_pkg::PIXEL_W'(pix_clamped);

    // A zero count halves the remainder toward zero.
    assign rem_bias = remainder_reg + $signed({{(RMW-1){1'b0}}, remainder_reg[RMW-1]});
    assign rem_half = rem_bias >>> 1;

    // The remainder moves only for a processed request with carry enabled.
    always_comb
    begin
        remainder_next = remainder_reg;
        if (ctrl.advance && ctrl.carry)
            remainder_next = ctrl.zero_count ? rem_half : rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remainder_reg <= '0;
        else
            remainder_reg <= remainder_next;
    end

    assign remainder = remainder_reg;

endmodule

>>> rtl/pointer_count_scaler.sv
// Pointer count scaler top level: input register, scaling datapath, result register.
// A request goes from the input register through the datapath into the result register.
// Throughput: one request per cycle unless output stalls; the remainder loop keeps up.
// A stalled result holds one more request in the input register before the input stalls.
// Reset clears the valid flags and remainder and loads the config reset values at once.
// Depends on pcs_pkg, pcs_in_if, pcs_out_if, pcs_cfg_regs, pcs_gain_select and pcs_accum.
module pointer_count_scaler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    pcs_in_if.sink                             in_ch,
    pcs_out_if.source                          out_ch
);

    pcs_pkg::cfg_t                        cfg;
    pcs_pkg::acc_ctrl_t                   acc_ctrl;
    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic signed [pcs_pkg::RAW_W-1:0]     in_raw_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [pcs_pkg::PIXEL_W-1:0]   out_pixel_reg;
    logic                                 advance;
    logic                                 in_take;
    logic signed [pcs_pkg::COUNT_W-1:0]   count;
    logic [pcs_pkg::GAIN_W-1:0]           gain;
    logic signed [pcs_pkg::PIXEL_W-1:0]   pixel_move;
    logic signed [pcs_pkg::REM_W-1:0]     remainder;

    // Configuration registers.
    pcs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the held request moves on whenever the result slot is free.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_raw_reg <= in_ch.raw_count;
        if (advance)
            out_pixel_reg <= pixel_move;
    end

    // Count saturation and gain.
    pcs_gain_select u_gain_select (
        .cfg       (cfg),
        .raw_count (in_raw_reg),
        .count     (count),
        .gain      (gain)
    );

    // Accumulate with the sub-pixel remainder and divide.
    assign acc_ctrl.advance    = advance;
    assign acc_ctrl.zero_count = (in_raw_reg == '0);
    assign acc_ctrl.carry      = cfg.carry_enable;

    pcs_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (acc_ctrl),
        .count      (count),
        .gain       (gain),
        .pixel_move (pixel_move),
        .remainder  (remainder)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_move = out_pixel_reg;

`ifndef SYNTHESIS
    // The kept remainder stays strictly inside one whole pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (remainder <= $signed(pcs_pkg::REM_W'((1 << pcs_pkg::FRACTION_BITS) - 1)))
        && (remainder >= -$signed(pcs_pkg::REM_W'((1 << pcs_pkg::FRACTION_BITS) - 1))))
        else $error("sub-pixel remainder out of range");

    // With carry off a processed request leaves the remainder alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg.carry_enable) |=> $stable(remainder))
        else $error("remainder changed with carry disabled");

    // A zero count gives a zero move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_raw_reg == '0) |=> (out_ch.valid && out_ch.pixel_move == '0))
        else $error("zero count did not give a zero move");

    // A presented result is within the pixel limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> ((out_ch.pixel_move <= $signed(pcs_pkg::PIXEL_W'(pcs_pkg::PIXEL_LIMIT)))
        && (out_ch.pixel_move >= -$signed(pcs_pkg::PIXEL_W'(pcs_pkg::PIXEL_LIMIT)))))
        else $error("pixel move beyond limit");
`endif

endmodule
